FILE: sv/gsa_pkg.sv
// gsa_pkg: shared constants, command codes, controller types and the
// exponential table helpers of the Gaussian splat accumulator.
// No dependencies.
package gsa_pkg;

   localparam int GSA_MAX_WIDTH      = 256;
   localparam int GSA_MAX_HEIGHT     = 256;
   localparam int GSA_EXP_TABLE_SIZE = 256;
   localparam int GSA_SUM_BITS       = 32;

   // exp table entries are Q.16, entry 0 is exactly 1.0
   localparam int EXP_BITS = 17;

   localparam logic [8:0] FRAME_DIM_RESET = 9'd256;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_SPLAT  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SPLAT,
      ST_DRAIN,
      ST_RD_ISSUE,
      ST_RD_LOAD,
      ST_RD_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch;
      logic peak_clear;
      logic clear_run;
      logic splat_run;
      logic rd_issue;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic pipe_busy;
      logic div_last;
   } dp_status_type;

   // exp(-x) in Q0.32 from a series truncated after the x^14 term, x given in Q.32
   function automatic logic [63:0] exp_ratio(input logic [63:0] x);
      logic [63:0] term;
      logic [63:0] r;
      term = 64'd1 << 32;
      r    = term;
      for (int i = 1; i <= 14; i++) begin
         term = ((term * x) >> 32) / 64'(i);
         if ((i & 1) != 0) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/gsa_idx_div.sv
// gsa_idx_div: pipelined restoring divider for the exp table index,
// one quotient bit per stage, carrying a tag alongside.
// Depends on nothing.
module gsa_idx_div #(
   parameter int QB = 8,
   parameter int NW = 40,
   parameter int TW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [TW-1:0] in_tag,
   input  logic [31:0]   divisor,
   output logic          out_valid,
   output logic [QB-1:0] out_quot,
   output logic [TW-1:0] out_tag,
   output logic          busy
);

   logic [QB-1:0] v_ff;
   logic [QB-1:0] v_in;
   logic [NW-1:0] rem_ff [QB];
   logic [NW-1:0] rem_in [QB];
   logic [QB-1:0] quo_ff [QB];
   logic [QB-1:0] quo_in [QB];
   logic [TW-1:0] tag_ff [QB];
   logic [TW-1:0] tag_in [QB];

   always_comb begin
      logic [NW-1:0] src;
      logic [NW-1:0] sub;
      logic [QB-1:0] qsrc;
      logic          ge;
      for (int s = 0; s < QB; s++) begin
         src  = (s == 0) ? in_num : rem_ff[(s == 0) ? 0 : s - 1];
         qsrc = (s == 0) ? '0 : quo_ff[(s == 0) ? 0 : s - 1];
         sub  = NW'(divisor) << (QB - 1 - s);
         ge   = (src >= sub);
         rem_in[s] = ge ? src - sub : src;
         quo_in[s] = qsrc | (QB'(ge) << (QB - 1 - s));
         tag_in[s] = (s == 0) ? in_tag : tag_ff[(s == 0) ? 0 : s - 1];
      end
      v_in = {v_ff[QB-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QB; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         tag_ff[s] <= tag_in[s];
      end
   end

   assign out_valid = v_ff[QB-1];
   assign out_quot  = quo_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];
   assign busy      = |v_ff;

endmodule

FILE: sv/gsa_dpath.sv
// gsa_dpath: frame scan counters, splat pipeline, RGB sum memories,
// running peak and the read normalizer. Uses gsa_pkg and gsa_idx_div.
module gsa_dpath #(
   parameter int MAX_WIDTH      = gsa_pkg::GSA_MAX_WIDTH,
   parameter int MAX_HEIGHT     = gsa_pkg::GSA_MAX_HEIGHT,
   parameter int EXP_TABLE_SIZE = gsa_pkg::GSA_EXP_TABLE_SIZE,
   parameter int SUM_BITS       = gsa_pkg::GSA_SUM_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gsa_pkg::ctrl_cmd_type  cmd,
   output gsa_pkg::dp_status_type status,
   input  logic [8:0]             cfg_width,
   input  logic [8:0]             cfg_height,
   input  logic [1:0]             req_command,
   input  logic signed [15:0]     req_center_x,
   input  logic signed [15:0]     req_center_y,
   input  logic [15:0]            req_spread,
   input  logic [15:0]            req_weight_red,
   input  logic [15:0]            req_weight_green,
   input  logic [15:0]            req_weight_blue,
   input  logic [7:0]             req_pixel_x,
   input  logic [7:0]             req_pixel_y,
   output logic [1:0]             rsp_done_kind,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue,
   output logic                   rsp_empty_frame
);
   import gsa_pkg::*;

   localparam int XW       = $clog2(MAX_WIDTH);
   localparam int YW       = $clog2(MAX_HEIGHT);
   localparam int AW       = XW + YW;
   localparam int Depth    = 1 << AW;
   localparam int WDW      = $clog2(MAX_WIDTH + 1);
   localparam int HDW      = $clog2(MAX_HEIGHT + 1);
   localparam int PW       = ((XW > YW) ? XW : YW) + 4;
   localparam int DW       = ((PW > 15) ? PW : 15) + 2;
   localparam int SQW      = 2 * DW;
   localparam int D2W      = SQW + 1;
   localparam int D2T      = 29;
   localparam int QB       = $clog2(EXP_TABLE_SIZE);
   localparam int NW       = QB + 32;
   localparam int PRW      = 17;
   localparam int NB       = SUM_BITS + 8;
   localparam int QuoBits  = 8;
   localparam int ByteMax  = 255;
   localparam int ExpScale = 8 * EXP_TABLE_SIZE;
   localparam logic [63:0] ExpStep = (64'd1 << 36) / EXP_TABLE_SIZE;

   typedef logic [EXP_BITS-1:0] rom_type [EXP_TABLE_SIZE];

   function automatic rom_type build_rom();
      logic [63:0] r;
      logic [63:0] cur;
      rom_type     t;
      r   = exp_ratio(ExpStep);
      cur = 64'd1 << 32;
      for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
         t[i] = EXP_BITS'((cur + 64'd32768) >> 16);
         cur  = (cur * r) >> 32;
      end
      return t;
   endfunction

   localparam rom_type ExpRom = build_rom();

   // item registers
   logic [1:0]           cmd_ff;
   logic signed [15:0]   cx_ff;
   logic signed [15:0]   cy_ff;
   logic [31:0]          s2_ff;
   logic [15:0]          w_ff [3];
   logic [AW-1:0]        rd_addr_ff;
   logic                 inside_ff;

   logic [WDW-1:0]       act_w;
   logic [HDW-1:0]       act_h;
   logic [15:0]          spread_eff;
   logic [XW-1:0]        x_ff;
   logic [YW-1:0]        y_ff;
   logic                 x_last;
   logic                 y_last;

   // splat pipeline
   logic                 a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, f_v_ff, g_v_ff;
   logic signed [DW-1:0] a_dx_ff, a_dy_ff;
   logic signed [DW-1:0] dx_in, dy_in;
   logic [AW-1:0]        a_addr_ff, b_addr_ff, c_addr_ff, d_addr_ff, e_addr_ff, f_addr_ff;
   logic [SQW-1:0]       b_sqx_ff, b_sqy_ff;
   logic [D2W-1:0]       c_d2_ff;
   logic                 d_in_range_ff;
   logic [NW-1:0]        d_num_ff;
   logic                 div_valid;
   logic [QB-1:0]        div_quot;
   logic [AW:0]          div_tag;
   logic                 div_busy;
   logic [EXP_BITS-1:0]  e_val_ff;
   logic [PRW-1:0]       f_pr_ff [3];
   logic [SUM_BITS-1:0]  g_sum_ff [3];
   logic [SUM_BITS-1:0]  sat_sum [3];
   logic [SUM_BITS-1:0]  peak_ff;
   logic [SUM_BITS-1:0]  peak_in;

   // sum memories
   logic [SUM_BITS-1:0]  sum_ff [3][Depth];
   logic [SUM_BITS-1:0]  rd_ff [3];
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic                 we;
   logic [SUM_BITS-1:0]  wdata [3];

   // read normalizer
   logic [NB-1:0]        rem_ff [3];
   logic [QuoBits-1:0]   quo_ff [3];
   logic                 sat_ff [3];
   logic [NB-1:0]        den_ff;
   logic [2:0]           step_ff;
   logic [7:0]           byte_val [3];
   logic                 show;

   always_comb begin
      if (cfg_width == '0) begin
         act_w = WDW'(1);
      end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
         act_w = WDW'(MAX_WIDTH);
      end else begin
         act_w = WDW'(cfg_width);
      end
      if (cfg_height == '0) begin
         act_h = HDW'(1);
      end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
         act_h = HDW'(MAX_HEIGHT);
      end else begin
         act_h = HDW'(cfg_height);
      end
      spread_eff = (req_spread == '0) ? 16'd1 : req_spread;
      x_last = (32'(x_ff) == 32'(act_w) - 32'd1);
      y_last = (32'(y_ff) == 32'(act_h) - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff     <= req_command;
         cx_ff      <= req_center_x;
         cy_ff      <= req_center_y;
         s2_ff      <= 32'(spread_eff) * 32'(spread_eff);
         w_ff[0]    <= req_weight_red;
         w_ff[1]    <= req_weight_green;
         w_ff[2]    <= req_weight_blue;
         rd_addr_ff <= {YW'(req_pixel_y), XW'(req_pixel_x)};
         inside_ff  <= (32'(req_pixel_x) < 32'(act_w)) && (32'(req_pixel_y) < 32'(act_h));
      end
   end

   // raster scan over the active frame
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (cmd.clear_run || cmd.splat_run) begin
         if (x_last) begin
            x_ff <= '0;
            y_ff <= y_ff + YW'(1);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
   end

   assign dx_in = $signed(DW'({x_ff, 4'b0000})) - DW'(cx_ff);
   assign dy_in = $signed(DW'({y_ff, 4'b0000})) - DW'(cy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
      end else begin
         a_v_ff <= cmd.splat_run;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= div_valid;
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_dx_ff       <= dx_in;
      a_dy_ff       <= dy_in;
      a_addr_ff     <= {y_ff, x_ff};
      b_sqx_ff      <= SQW'(a_dx_ff * a_dx_ff);
      b_sqy_ff      <= SQW'(a_dy_ff * a_dy_ff);
      b_addr_ff     <= a_addr_ff;
      c_d2_ff       <= D2W'(b_sqx_ff) + D2W'(b_sqy_ff);
      c_addr_ff     <= b_addr_ff;
      // the table reaches only while 8*d2 stays below sigma squared
      d_in_range_ff <= {c_d2_ff, 3'b000} < (D2W + 3)'(s2_ff);
      d_num_ff      <= NW'(c_d2_ff[D2T-1:0]) * NW'(ExpScale);
      d_addr_ff     <= c_addr_ff;
      e_val_ff      <= div_tag[AW] ? ExpRom[div_quot] : '0;
      e_addr_ff     <= div_tag[AW-1:0];
      f_addr_ff     <= e_addr_ff;
      for (int c = 0; c < 3; c++) begin
         f_pr_ff[c]  <= PRW'((33'(e_val_ff) * 33'(w_ff[c])) >> 16);
         g_sum_ff[c] <= sat_sum[c];
      end
   end

   gsa_idx_div #(
      .QB (QB),
      .NW (NW),
      .TW (AW + 1)
   ) u_idx_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_v_ff),
      .in_num    (d_num_ff),
      .in_tag    ({d_in_range_ff, d_addr_ff}),
      .divisor   (s2_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag),
      .busy      (div_busy)
   );

   always_comb begin
      logic [SUM_BITS:0] wide;
      for (int c = 0; c < 3; c++) begin
         wide       = (SUM_BITS + 1)'(rd_ff[c]) + (SUM_BITS + 1)'(f_pr_ff[c]);
         sat_sum[c] = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
         wdata[c]   = f_v_ff ? sat_sum[c] : '0;
      end
      we    = f_v_ff || cmd.clear_run;
      waddr = f_v_ff ? f_addr_ff : {y_ff, x_ff};
      raddr = cmd.rd_issue ? rd_addr_ff : e_addr_ff;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (we) begin
            sum_ff[c][waddr] <= wdata[c];
         end
         rd_ff[c] <= sum_ff[c][raddr];
      end
   end

   always_comb begin
      logic [SUM_BITS-1:0] m01;
      logic [SUM_BITS-1:0] m2p;
      m01 = (g_sum_ff[0] > g_sum_ff[1]) ? g_sum_ff[0] : g_sum_ff[1];
      m2p = (g_sum_ff[2] > peak_ff) ? g_sum_ff[2] : peak_ff;
      peak_in = peak_ff;
      if (cmd.peak_clear) begin
         peak_in = '0;
      end else if (g_v_ff) begin
         peak_in = (m01 > m2p) ? m01 : m2p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else begin
         peak_ff <= peak_in;
      end
   end

   // sum*255/peak, eight quotient bits, saturate when it would pass 255
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= NB'(rd_ff[c]) * NB'(ByteMax);
            sat_ff[c] <= (NB'(rd_ff[c]) * NB'(ByteMax)) >= (NB'(peak_ff) << QuoBits);
            quo_ff[c] <= '0;
         end
         den_ff  <= NB'(peak_ff) << (QuoBits - 1);
         step_ff <= 3'(QuoBits - 1);
      end else if (cmd.div_step) begin
         for (int c = 0; c < 3; c++) begin
            if (rem_ff[c] >= den_ff) begin
               rem_ff[c] <= rem_ff[c] - den_ff;
               quo_ff[c] <= {quo_ff[c][QuoBits-2:0], 1'b1};
            end else begin
               quo_ff[c] <= {quo_ff[c][QuoBits-2:0], 1'b0};
            end
         end
         den_ff  <= den_ff >> 1;
         step_ff <= step_ff - 3'd1;
      end
   end

   always_comb begin
      show = (cmd_ff == CMD_READ) && (peak_ff != '0) && inside_ff;
      for (int c = 0; c < 3; c++) begin
         byte_val[c] = !show ? 8'd0 : (sat_ff[c] ? 8'(ByteMax) : quo_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_done_kind   <= cmd_ff;
         rsp_out_red     <= byte_val[0];
         rsp_out_green   <= byte_val[1];
         rsp_out_blue    <= byte_val[2];
         rsp_empty_frame <= (cmd_ff == CMD_READ) && (peak_ff == '0);
      end
   end

   assign status.scan_last = x_last && y_last;
   assign status.pipe_busy = a_v_ff || b_v_ff || c_v_ff || d_v_ff || div_busy ||
                             e_v_ff || f_v_ff || g_v_ff;
   assign status.div_last  = (step_ff == 3'd0);

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(f_v_ff && cmd.clear_run))
      else $error("splat write-back collides with clear sweep");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !cmd.peak_clear |=> peak_ff >= $past(peak_ff))
      else $error("running peak dropped without a clear");

endmodule

FILE: sv/gsa_ctrl.sv
// gsa_ctrl: command sequencer of the splat accumulator; drives the
// datapath through gsa_pkg command and status structs.
module gsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_command,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gsa_pkg::ctrl_cmd_type  cmd,
   input  gsa_pkg::dp_status_type status
);
   import gsa_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (req_command)
                  CMD_CLEAR: begin
                     cmd.peak_clear = 1'b1;
                     state_in       = ST_CLEAR;
                  end
                  CMD_SPLAT: state_in = ST_SPLAT;
                  CMD_READ:  state_in = ST_RD_ISSUE;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SPLAT: begin
            cmd.splat_run = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RD_LOAD;
         end
         ST_RD_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_RD_DIV;
         end
         ST_RD_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten before transfer");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !status.pipe_busy)
      else $error("splat pipeline busy while idle");

endmodule

FILE: sv/gaussian_splat_accumulator.sv
// gaussian_splat_accumulator: top level with the frame size registers.
// Uses gsa_pkg, gsa_ctrl and gsa_dpath.
//
//   channel   direction  handshake                 contents
//   req_*     in         req_valid / req_stall     command and splat/read fields
//   rsp_*     out        rsp_valid / rsp_stall     done_kind, RGB bytes, empty_frame
//   p*        in/out     psel/penable/pwrite       frame_width @0x0, frame_height @0x4
//
// Clear writes one pixel per cycle.
// Splat scans one pixel per cycle; each of the three sum memories is read
// and written back once per pixel.
// Read runs the bit-serial normalizing divider.
// Reset is synchronous; the sum memories hold garbage until a clear.
// A result waiting under rsp_stall holds the next item only in its finish state.
module gaussian_splat_accumulator #(
   parameter int MAX_WIDTH      = gsa_pkg::GSA_MAX_WIDTH,
   parameter int MAX_HEIGHT     = gsa_pkg::GSA_MAX_HEIGHT,
   parameter int EXP_TABLE_SIZE = gsa_pkg::GSA_EXP_TABLE_SIZE,
   parameter int SUM_BITS       = gsa_pkg::GSA_SUM_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_center_x,
   input  logic signed [15:0] req_center_y,
   input  logic [15:0]        req_spread,
   input  logic [15:0]        req_weight_red,
   input  logic [15:0]        req_weight_green,
   input  logic [15:0]        req_weight_blue,
   input  logic [7:0]         req_pixel_x,
   input  logic [7:0]         req_pixel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_done_kind,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   output logic               rsp_empty_frame,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import gsa_pkg::*;

   logic [8:0]    frame_width_ff;
   logic [8:0]    frame_height_ff;
   logic          csr_index;
   logic          csr_write;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // word address selects the register, byte lanes ignored
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_DIM_RESET;
         frame_height_ff <= FRAME_DIM_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            frame_width_ff <= pwdata[8:0];
         end else begin
            frame_height_ff <= pwdata[8:0];
         end
      end
   end

   assign prdata = (csr_index == REG_FRAME_HEIGHT) ? 32'(frame_height_ff)
                                                   : 32'(frame_width_ff);

   gsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   gsa_dpath #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .EXP_TABLE_SIZE (EXP_TABLE_SIZE),
      .SUM_BITS       (SUM_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg_width        (frame_width_ff),
      .cfg_height       (frame_height_ff),
      .req_command      (req_command),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_spread       (req_spread),
      .req_weight_red   (req_weight_red),
      .req_weight_green (req_weight_green),
      .req_weight_blue  (req_weight_blue),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_done_kind    (rsp_done_kind),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_empty_frame  (rsp_empty_frame)
   );

endmodule

FILE: sim/gaussian_splat_accumulator_tb.sv
// Self-checking testbench for the Gaussian splat accumulator: drives clear, splat,
// read and unused commands and checks each response against a predictor in the bench.
// Depends on gsa_pkg and gaussian_splat_accumulator.
`timescale 1ns / 100ps

module gaussian_splat_accumulator_tb;
   import gsa_pkg::*;

   localparam logic [1:0] CMD_UNUSED        = 2'd3;
   localparam logic [2:0] ADDR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_FRAME_HEIGHT = 3'd4;
   localparam int         PIXELS            = GSA_MAX_WIDTH * GSA_MAX_HEIGHT;

   typedef struct {
      logic [1:0]         command;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        spread;
      logic [15:0]        weight_red;
      logic [15:0]        weight_green;
      logic [15:0]        weight_blue;
      logic [7:0]         pixel_x;
      logic [7:0]         pixel_y;
   } splat_req_type;

   typedef struct {
      logic [1:0] done_kind;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       empty_frame;
   } pixel_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_CLEAR;
   logic signed [15:0] req_center_x = '0;
   logic signed [15:0] req_center_y = '0;
   logic [15:0]        req_spread = '0;
   logic [15:0]        req_weight_red = '0;
   logic [15:0]        req_weight_green = '0;
   logic [15:0]        req_weight_blue = '0;
   logic [7:0]         req_pixel_x = '0;
   logic [7:0]         req_pixel_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_done_kind;
   logic [7:0]         rsp_out_red;
   logic [7:0]         rsp_out_green;
   logic [7:0]         rsp_out_blue;
   logic               rsp_empty_frame;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   gaussian_splat_accumulator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_center_x(req_center_x), .req_center_y(req_center_y), .req_spread(req_spread),
      .req_weight_red(req_weight_red), .req_weight_green(req_weight_green),
      .req_weight_blue(req_weight_blue), .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_done_kind(rsp_done_kind),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_empty_frame(rsp_empty_frame),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frame store mirror
   bit [31:0]          acc_red [PIXELS];
   bit [31:0]          acc_green [PIXELS];
   bit [31:0]          acc_blue [PIXELS];
   bit                 cleared_map [PIXELS];
   bit [31:0]          peak_level = 0;
   bit [8:0]           width_reg = FRAME_DIM_RESET;
   bit [8:0]           height_reg = FRAME_DIM_RESET;
   longint unsigned    exp_lut [GSA_EXP_TABLE_SIZE];

   pixel_result_type   pending_results [$];
   int                 mismatches = 0;
   int                 stall_left = 0;
   bit                 hold_rsp = 1'b0;
   bit                 quiet = 1'b0;

   function automatic void build_exp_lut();
      longint unsigned x;
      longint unsigned term;
      longint unsigned r;
      longint unsigned cur;
      x = 64'd1 << 28;
      term = 64'd1 << 32;
      r = term;
      cur = 64'd1 << 32;
      for (int i = 1; i <= 14; i++) begin
         term = ((term * x) >> 32) / longint'(i);
         if (i % 2 == 1) r = r - term;
         else r = r + term;
      end
      for (int i = 0; i < GSA_EXP_TABLE_SIZE; i++) begin
         exp_lut[i] = (cur + 64'd32768) >> 16;
         cur = (cur * r) >> 32;
      end
   endfunction

   function automatic int active_dim(bit [8:0] v);
      if (v == 0) return 1;
      if (v > GSA_MAX_WIDTH) return GSA_MAX_WIDTH;
      return int'(v);
   endfunction

   function automatic bit [31:0] sat_add(bit [31:0] a, longint unsigned b);
      longint unsigned t;
      t = longint'(a) + b;
      return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   function automatic logic [7:0] scale_byte(bit [31:0] s);
      longint unsigned q;
      q = (longint'(s) * 255) / longint'(peak_level);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic bit region_cleared();
      int w;
      int h;
      w = active_dim(width_reg);
      h = active_dim(height_reg);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            if (!cleared_map[y * GSA_MAX_WIDTH + x]) return 1'b0;
      return 1'b1;
   endfunction

   // advance the store mirror by one command and return its response
   function automatic pixel_result_type apply_command(splat_req_type q);
      pixel_result_type res;
      int              w;
      int              h;
      int              idx;
      longint          dx;
      longint          dy;
      longint unsigned sx;
      longint unsigned d2;
      longint unsigned k;
      longint unsigned e;
      res = '{q.command, 8'd0, 8'd0, 8'd0, 1'b0};
      w = active_dim(width_reg);
      h = active_dim(height_reg);
      case (q.command)
         CMD_CLEAR: begin
            for (int y = 0; y < h; y++)
               for (int x = 0; x < w; x++) begin
                  idx = y * GSA_MAX_WIDTH + x;
                  acc_red[idx] = 0;
                  acc_green[idx] = 0;
                  acc_blue[idx] = 0;
                  cleared_map[idx] = 1'b1;
               end
            peak_level = 0;
         end
         CMD_SPLAT: begin
            sx = (q.spread == 0) ? 1 : longint'(q.spread);
            for (int y = 0; y < h; y++) begin
               dy = longint'(y) * 16 - longint'(q.center_y);
               for (int x = 0; x < w; x++) begin
                  dx = longint'(x) * 16 - longint'(q.center_x);
                  d2 = longint'(dx * dx) + longint'(dy * dy);
                  k = (d2 * 2048) / (sx * sx);
                  e = (k < GSA_EXP_TABLE_SIZE) ? exp_lut[k] : 0;
                  idx = y * GSA_MAX_WIDTH + x;
                  acc_red[idx] = sat_add(acc_red[idx], (e * q.weight_red) >> 16);
                  if (acc_red[idx] > peak_level) peak_level = acc_red[idx];
                  acc_green[idx] = sat_add(acc_green[idx], (e * q.weight_green) >> 16);
                  if (acc_green[idx] > peak_level) peak_level = acc_green[idx];
                  acc_blue[idx] = sat_add(acc_blue[idx], (e * q.weight_blue) >> 16);
                  if (acc_blue[idx] > peak_level) peak_level = acc_blue[idx];
               end
            end
         end
         CMD_READ: begin
            if (peak_level == 0) begin
               res.empty_frame = 1'b1;
            end else if (q.pixel_x < w && q.pixel_y < h) begin
               idx = int'(q.pixel_y) * GSA_MAX_WIDTH + int'(q.pixel_x);
               res.out_red = scale_byte(acc_red[idx]);
               res.out_green = scale_byte(acc_green[idx]);
               res.out_blue = scale_byte(acc_blue[idx]);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // response side: check each transfer, stall at random or while held
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: kind %0d", rsp_done_kind);
            end else begin
               want = pending_results.pop_front();
               if (rsp_done_kind !== want.done_kind || rsp_out_red !== want.out_red ||
                   rsp_out_green !== want.out_green || rsp_out_blue !== want.out_blue ||
                   rsp_empty_frame !== want.empty_frame) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected kind %0d rgb %0d %0d %0d empty %0d,",
                               " got kind %0d rgb %0d %0d %0d empty %0d"},
                              want.done_kind, want.out_red, want.out_green, want.out_blue,
                              want.empty_frame, rsp_done_kind, rsp_out_red, rsp_out_green,
                              rsp_out_blue, rsp_empty_frame);
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 14);
         end
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_req(splat_req_type q);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= q.command;
      req_center_x <= q.center_x;
      req_center_y <= q.center_y;
      req_spread <= q.spread;
      req_weight_red <= q.weight_red;
      req_weight_green <= q.weight_green;
      req_weight_blue <= q.weight_blue;
      req_pixel_x <= q.pixel_x;
      req_pixel_y <= q.pixel_y;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_command(q));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_clear();
      send_req('{CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)});
   endtask

   // clear first where the active frame still holds unwritten pixels
   task automatic send_splat(logic signed [15:0] cx, logic signed [15:0] cy,
                             logic [15:0] spread, logic [15:0] wr, logic [15:0] wg,
                             logic [15:0] wb);
      if (!region_cleared()) send_clear();
      send_req('{CMD_SPLAT, cx, cy, spread, wr, wg, wb, 8'($urandom), 8'($urandom)});
   endtask

   task automatic send_read(logic [7:0] px, logic [7:0] py);
      if (px < active_dim(width_reg) && py < active_dim(height_reg) &&
          !cleared_map[int'(py) * GSA_MAX_WIDTH + int'(px)]) begin
         px = 8'd0;
         py = 8'd0;
      end
      send_req('{CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), px, py});
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(bit [8:0] w, bit [8:0] h);
      wait_drain();
      csr_write(ADDR_FRAME_WIDTH, {23'd0, w});
      csr_write(ADDR_FRAME_HEIGHT, {23'd0, h});
      width_reg = w;
      height_reg = h;
   endtask

   task automatic hold_responses(int cycles);
      hold_rsp <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   task automatic test_empty_frame();
      set_frame(9'd4, 9'd4);
      send_clear();
      send_read(8'd0, 8'd0);
      send_read(8'd3, 8'd3);
   endtask

   task automatic test_directed_splats();
      send_splat(16'sd24, 16'sd24, 16'h0100, 16'hFFFF, 16'h8000, 16'h0000);
      send_read(8'd1, 8'd1);
      send_read(8'd3, 8'd0);
      send_splat(-16'sd32768, 16'sd32767, 16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF);
      send_splat(16'sd32767, -16'sd32768, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_splat(16'sd0, 16'sd0, 16'h0000, 16'hFFFF, 16'h0001, 16'hABCD);
      send_splat(16'sd16, 16'sd32, 16'h0200, 16'h0000, 16'h0000, 16'h0000);
      send_read(8'd0, 8'd0);
      send_read(8'd2, 8'd3);
      send_read(8'd200, 8'd255);
      send_req('{CMD_UNUSED, 16'sh7FFF, 16'sh8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 8'hFF, 8'hFF});
      send_read(8'd0, 8'd0);
   endtask

   // splat, shrink, clear and splat faintly so older pixels exceed the new peak, then regrow and read
   task automatic test_stale_pixels();
      set_frame(9'd8, 9'd8);
      send_clear();
      send_splat(16'sd96, 16'sd96, 16'h0400, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_frame(9'd2, 9'd2);
      send_clear();
      send_splat(16'sd0, 16'sd0, 16'h0100, 16'h0100, 16'h0080, 16'h0040);
      set_frame(9'd8, 9'd8);
      send_read(8'd6, 8'd6);
      send_read(8'd0, 8'd0);
      send_read(8'd1, 8'd1);
   endtask

   task automatic test_register_extremes();
      set_frame(9'd511, 9'd0);
      send_clear();
      send_splat(16'sd2000, 16'sd0, 16'h0800, 16'hFFFF, 16'h4000, 16'h0100);
      send_read(8'd255, 8'd0);
      send_read(8'd125, 8'd0);
      send_read(8'd3, 8'd1);
      set_frame(9'd0, 9'd511);
      send_splat(16'sd0, 16'sd4080, 16'h1000, 16'h8000, 16'hFFFF, 16'h2000);
      send_read(8'd0, 8'd255);
      set_frame(9'd256, 9'd256);
      send_clear();
      send_splat(16'sd2048, 16'sd2048, 16'h2000, 16'hFFFF, 16'h7777, 16'h0F0F);
      send_read(8'd128, 8'd128);
      send_read(8'd255, 8'd255);
      send_read(8'd100, 8'd140);
   endtask

   task automatic test_backpressure();
      set_frame(9'd4, 9'd4);
      quiet = 1'b1;
      fork
         hold_responses(300);
         repeat (12) send_read(8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)));
      join
      wait_drain();
      send_splat(16'sd8, 16'sd40, 16'h0180, 16'($urandom), 16'($urandom), 16'($urandom));
      send_read(8'd0, 8'd2);
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      int pick;
      int w;
      int h;
      for (int phase = 0; phase < 4; phase++) begin
         set_frame(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
         quiet = (phase == 2);
         w = active_dim(width_reg);
         h = active_dim(height_reg);
         for (int n = 0; n < 13; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_clear();
            end else if (pick < 12) begin
               send_req('{CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom)});
            end else if (pick < 40) begin
               send_splat(16'($urandom_range(0, w * 16)), 16'($urandom_range(0, h * 16)),
                          16'($urandom_range(16'h0080, 16'h0800)), 16'($urandom),
                          16'($urandom), 16'($urandom));
            end else if (pick < 48) begin
               send_splat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            end else if (pick < 90) begin
               send_read(8'($urandom_range(0, w)), 8'($urandom_range(0, h)));
            end else begin
               send_read(8'($urandom), 8'($urandom));
            end
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      build_exp_lut();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_frame();
      test_directed_splats();
      test_stale_pixels();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      wait_drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule
